/* src/pmi_pkg.sv */
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared widths, result codes and interface types for the polygon mass and
// inertia block.
// ----------------------------------------------------------------------------
package pmi_pkg;

    localparam int COORD_W      = 16;
    localparam int DENS_W       = 16;
    localparam int CNT_W        = 9;
    localparam int MAX_VERTICES = 256;
    localparam int AREA_W       = 40;
    localparam int MOM_W        = 64;
    localparam int OUT_W        = 48;
    localparam int STATUS_W     = 2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Divider: divisor is 6 * the accumulated area, quotient is the Q16.16 inertia.
    localparam int DIV_D_W   = AREA_W + 3;
    localparam int DIV_Q_W   = OUT_W;
    localparam int DIV_CNT_W = 6;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_AREA = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

    typedef struct packed {
        logic               start;
        logic [31:0]        num_hi;
        logic [31:0]        num_lo;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } div_stat_t;

endpackage

/* src/polygon_mass_and_inertia.sv */
// ----------------------------------------------------------------------------
// polygon_mass_and_inertia
// Accumulates polygon area and second moment vertex by vertex and reports
// mass and inertia per unit mass when the last vertex arrives.
// ----------------------------------------------------------------------------
// The first vertex of a polygon is stored; each further vertex makes ten
// passes through the one shared multiplier for its edge.
// A last vertex adds the closing edge, the mass products and a bit-serial
// division before the result is offered.
// One item at a time; s_tready is high only while the sequencer is idle.
// Synchronous active-low reset clears the polygon state, sets density to 1.0.
module polygon_mass_and_inertia
    import pmi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Vertex stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // vertex_x [15:0], vertex_y [31:16]
    input  logic                  s_tlast,   // last_vertex
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,   // mass_out [47:0], inertia_out [95:48]
    output logic [STATUS_W-1:0]   m_tuser,   // status [1:0]
    // Density register write.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DENS_W-1:0]     cfg_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PROD      = 4'd1;
    localparam logic [3:0] ST_AB        = 4'd2;
    localparam logic [3:0] ST_ACC       = 4'd3;
    localparam logic [3:0] ST_FIN       = 4'd4;
    localparam logic [3:0] ST_MASS      = 4'd5;
    localparam logic [3:0] ST_DIV_START = 4'd6;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd7;
    localparam logic [3:0] ST_OUT       = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;

    logic [DENS_W-1:0] density_reg, density_next;

    logic signed [COORD_W-1:0] first_x_reg, first_x_next;
    logic signed [COORD_W-1:0] first_y_reg, first_y_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] qy_reg, qy_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [MOM_W-1:0]  moment_reg, moment_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    logic              close_reg, close_next;

    logic signed [32:0] cross_reg, cross_next;
    logic signed [34:0] b_reg, b_next;
    logic [48:0]        ab_lo_reg, ab_lo_next;
    logic [47:0]        ab_reg, ab_next;
    logic [47:0]        mass_lo_reg, mass_lo_next;

    logic [OUT_W-1:0]    res_mass_reg, res_mass_next;
    logic [OUT_W-1:0]    res_inertia_reg, res_inertia_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                m_valid_reg, m_valid_next;
    logic [95:0]         m_data_reg, m_data_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [DIV_Q_W-1:0] quotient;

    logic signed [COORD_W-1:0] in_x, in_y;
    logic                      s_fire;
    logic [31:0]               a_val;
    logic [63:0]               ab_full;
    logic [AREA_W:0]           area_sum;
    logic [MOM_W:0]            moment_sum;
    logic [55:0]               mass_full;

    assign in_x   = s_tdata[15:0];
    assign in_y   = s_tdata[31:16];
    assign s_fire = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Absolute cross product; the magnitude never exceeds 2^31.
    assign a_val = cross_reg[32] ? 32'(-cross_reg) : 32'(cross_reg);

    assign ab_full    = {15'b0, ab_lo_reg} + {prod[46:0], 17'b0};
    assign area_sum   = {1'b0, area_reg} + {{(AREA_W-31){1'b0}}, a_val};
    assign moment_sum = {1'b0, moment_reg} + {{(MOM_W-47){1'b0}}, ab_reg};
    assign mass_full  = {8'b0, mass_lo_reg} + {prod[23:0], 32'b0};

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_PROD) begin
            case (step_reg)
                4'd0: begin mul_a = MUL_A_W'(px_reg); mul_b = MUL_B_W'(qy_reg); end
                4'd1: begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(py_reg); end
                4'd2: begin mul_a = MUL_A_W'(px_reg); mul_b = MUL_B_W'(px_reg); end
                4'd3: begin mul_a = MUL_A_W'(py_reg); mul_b = MUL_B_W'(py_reg); end
                4'd4: begin mul_a = MUL_A_W'(px_reg); mul_b = MUL_B_W'(qx_reg); end
                4'd5: begin mul_a = MUL_A_W'(py_reg); mul_b = MUL_B_W'(qy_reg); end
                4'd6: begin mul_a = MUL_A_W'(qx_reg); mul_b = MUL_B_W'(qx_reg); end
                4'd7: begin mul_a = MUL_A_W'(qy_reg); mul_b = MUL_B_W'(qy_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_AB) begin
            mul_a = {1'b0, a_val};
            if (step_reg == 4'd0) begin
                mul_b = {1'b0, b_reg[16:0]};
            end else begin
                mul_b = {2'b0, b_reg[32:17]};
            end
        end else if (state_reg == ST_MASS) begin
            mul_b = {2'b0, density_reg};
            if (step_reg == 4'd0) begin
                mul_a = {1'b0, area_reg[31:0]};
            end else begin
                mul_a = {25'b0, area_reg[39:32]};
            end
        end
    end

    assign div_req.start   = (state_reg == ST_DIV_START);
    assign div_req.num_hi  = moment_reg[63:32];
    assign div_req.num_lo  = moment_reg[31:0];
    assign div_req.divisor = {1'b0, area_reg, 2'b0} + {2'b0, area_reg, 1'b0};

    pmi_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pmi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        density_next     = density_reg;
        first_x_next     = first_x_reg;
        first_y_next     = first_y_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        count_next       = count_reg;
        area_next        = area_reg;
        moment_next      = moment_reg;
        ovf_next         = ovf_reg;
        last_next        = last_reg;
        close_next       = close_reg;
        cross_next       = cross_reg;
        b_next           = b_reg;
        ab_lo_next       = ab_lo_reg;
        ab_next          = ab_reg;
        mass_lo_next     = mass_lo_reg;
        res_mass_next    = res_mass_reg;
        res_inertia_next = res_inertia_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            density_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    prev_x_next = in_x;
                    prev_y_next = in_y;
                    if (count_reg != CNT_W'(MAX_VERTICES)) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (count_reg == '0) begin
                        first_x_next = in_x;
                        first_y_next = in_y;
                        if (s_tlast) begin
                            // A lone vertex reports 5 * density in Q16.16.
                            res_mass_next = OUT_W'({density_reg, 10'b0})
                                          + OUT_W'({density_reg, 8'b0});
                            res_inertia_next = '0;
                            res_status_next  = STATUS_SINGLE;
                            state_next       = ST_OUT;
                        end
                    end else begin
                        px_next    = prev_x_reg;
                        py_next    = prev_y_reg;
                        qx_next    = in_x;
                        qy_next    = in_y;
                        last_next  = s_tlast;
                        close_next = s_tlast;
                        step_next  = '0;
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD: begin
                // Products come back in the cycle after their operands.
                case (step_reg)
                    4'd1: cross_next = 33'(prod);
                    4'd2: cross_next = cross_reg - 33'(prod);
                    4'd3: b_next     = 35'(prod);
                    4'd4, 4'd5, 4'd6, 4'd7, 4'd8: b_next = b_reg + 35'(prod);
                    default: b_next  = b_reg;
                endcase
                if (step_reg == 4'd8) begin
                    step_next  = '0;
                    state_next = ST_AB;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_AB: begin
                if (step_reg == 4'd1) begin
                    ab_lo_next = prod[48:0];
                end
                if (step_reg == 4'd2) begin
                    ab_next    = ab_full[63:16];
                    step_next  = '0;
                    state_next = ST_ACC;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ACC: begin
                if (area_sum[AREA_W]) begin
                    area_next = {AREA_W{1'b1}};
                    ovf_next  = 1'b1;
                end else begin
                    area_next = area_sum[AREA_W-1:0];
                end
                if (moment_sum[MOM_W]) begin
                    moment_next = {MOM_W{1'b1}};
                    ovf_next    = 1'b1;
                end else begin
                    moment_next = moment_sum[MOM_W-1:0];
                end
                if (close_reg) begin
                    // Closing edge runs from the last vertex back to the first.
                    px_next    = qx_reg;
                    py_next    = qy_reg;
                    qx_next    = first_x_reg;
                    qy_next    = first_y_reg;
                    close_next = 1'b0;
                    step_next  = '0;
                    state_next = ST_PROD;
                end else if (last_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (area_reg == '0) begin
                    res_mass_next    = '0;
                    res_inertia_next = '0;
                    res_status_next  = STATUS_ZERO_AREA;
                    state_next       = ST_OUT;
                end else begin
                    step_next  = '0;
                    state_next = ST_MASS;
                end
            end
            ST_MASS: begin
                if (step_reg == 4'd1) begin
                    mass_lo_next = prod[47:0];
                end
                if (step_reg == 4'd2) begin
                    res_mass_next = {1'b0, mass_full[55:9]};
                    step_next     = '0;
                    state_next    = ST_DIV_START;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    res_inertia_next = div_stat.overflow ? OUT_MAX : quotient;
                    res_status_next  = (div_stat.overflow || ovf_reg) ?
                                       STATUS_SATURATED : STATUS_OK;
                    state_next       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_inertia_reg, res_mass_reg};
                    m_user_next  = res_status_reg;
                    first_x_next = '0;
                    first_y_next = '0;
                    prev_x_next  = '0;
                    prev_y_next  = '0;
                    count_next   = '0;
                    area_next    = '0;
                    moment_next  = '0;
                    ovf_next     = 1'b0;
                    last_next    = 1'b0;
                    close_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            density_reg <= DENS_W'(256);
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
            area_reg    <= '0;
            moment_reg  <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            close_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            density_reg <= density_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            count_reg   <= count_next;
            area_reg    <= area_next;
            moment_reg  <= moment_next;
            ovf_reg     <= ovf_next;
            last_reg    <= last_next;
            close_reg   <= close_next;
            m_valid_reg <= m_valid_next;
        end
        px_reg          <= px_next;
        py_reg          <= py_next;
        qx_reg          <= qx_next;
        qy_reg          <= qy_next;
        cross_reg       <= cross_next;
        b_reg           <= b_next;
        ab_lo_reg       <= ab_lo_next;
        ab_reg          <= ab_next;
        mass_lo_reg     <= mass_lo_next;
        res_mass_reg    <= res_mass_next;
        res_inertia_reg <= res_inertia_next;
        res_status_reg  <= res_status_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* src/pmi_mul.sv */
// ----------------------------------------------------------------------------
// pmi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pmi_mul
    import pmi_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* src/pmi_div.sv */
// ----------------------------------------------------------------------------
// pmi_div
// Restoring divider, one quotient bit per cycle. Computes
// floor({num_hi, num_lo, 16'b0} / divisor) and flags a quotient that does
// not fit the output width.
// ----------------------------------------------------------------------------
module pmi_div
    import pmi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  div_req_t           req,
    output div_stat_t          stat,
    output logic [DIV_Q_W-1:0] quotient
);

    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   div_reg, div_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg, ovf_next;

    logic [DIV_D_W:0] shifted;
    logic [DIV_D_W:0] diff;
    logic             ge;
    logic             too_big;

    assign shifted = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = (shifted >= {1'b0, div_reg});
    // The quotient overflows exactly when the upper 32 bits of the numerator,
    // num_hi, already reach the divisor.
    assign too_big = ({{(DIV_D_W-32){1'b0}}, req.num_hi} >= req.divisor);

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (req.start) begin
            ovf_next = too_big;
            rem_next = {{(DIV_D_W-32){1'b0}}, req.num_hi};
            quo_next = {req.num_lo, 16'b0};
            div_next = req.divisor;
            cnt_next = '0;
            if (too_big) begin
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;
    assign quotient      = quo_reg;

endmodule

/* tb/tb_polygon_mass_and_inertia.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_mass_and_inertia
// Streams polygons into the mass and inertia block and checks each result
// against a cycle-free model of the area and moment sums. It covers directed
// shapes, density extremes, the vertex count limit, area saturation and long
// random runs, with random gaps on the vertex stream and random result stalls.
// ----------------------------------------------------------------------------
module tb_polygon_mass_and_inertia
    import pmi_pkg::*;
();

    typedef struct packed {
        logic [OUT_W-1:0]    mass;
        logic [OUT_W-1:0]    inertia;
        logic [STATUS_W-1:0] status;
    } polygon_body_t;

    localparam logic [AREA_W-1:0] AREA_LIMIT  = {AREA_W{1'b1}};
    localparam int                IDLE_CYCLES = 120;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;   // vertex_x [15:0], vertex_y [31:16]
    logic                s_tlast = 1'b0; // last_vertex
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [95:0]         m_tdata;        // mass_out [47:0], inertia_out [95:48]
    logic [STATUS_W-1:0] m_tuser;        // status [1:0]
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [DENS_W-1:0]   cfg_data = '0;

    polygon_mass_and_inertia dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Model state of the polygon being accumulated.
    logic [DENS_W-1:0]        body_density = 16'd256;
    logic signed [COORD_W-1:0] first_x = '0, first_y = '0;
    logic signed [COORD_W-1:0] prev_x = '0, prev_y = '0;
    int                       vertices_in_polygon = 0;
    logic [AREA_W-1:0]        area_sum = '0;
    logic [MOM_W-1:0]         moment_sum = '0;
    logic                     sums_saturated = 1'b0;

    polygon_body_t pending_bodies[$];
    polygon_body_t oldest_body;

    int error_count = 0;
    int burst_left = 0;
    int vertices_sent = 0;
    int polygons_sent = 0;
    int density_writes = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int ready_pct = 100;
    int stretch_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Adds one edge (p, q) to the running area and moment sums.
    function automatic void add_edge(input logic signed [COORD_W-1:0] px, py, qx, qy);
        logic signed [63:0] ax, ay, bx, by, cross_prod, spread;
        logic [127:0]       weighted;
        logic [63:0]        area_step, moment_step;
        logic [64:0]        area_wide, moment_wide;
        ax = px;
        ay = py;
        bx = qx;
        by = qy;
        cross_prod = ax * by - bx * ay;
        spread     = ax * ax + ay * ay + ax * bx + ay * by + bx * bx + by * by;
        area_step = (cross_prod < 0) ? -cross_prod : cross_prod;
        weighted = {64'd0, area_step} * {64'd0, spread};
        moment_step = weighted[79:16];
        area_wide = {25'd0, area_sum} + {1'b0, area_step};
        if (area_wide > {25'd0, AREA_LIMIT}) begin
            area_sum = AREA_LIMIT;
            sums_saturated = 1'b1;
        end else begin
            area_sum = area_wide[AREA_W-1:0];
        end
        moment_wide = {1'b0, moment_sum} + {1'b0, moment_step};
        if (moment_wide[64]) begin
            moment_sum = '1;
            sums_saturated = 1'b1;
        end else begin
            moment_sum = moment_wide[63:0];
        end
    endfunction

    // Folds one accepted vertex into the model; a last vertex closes the
    // polygon and queues the expected body.
    function automatic void accumulate_vertex(input logic signed [COORD_W-1:0] x, y,
                                              input logic last);
        polygon_body_t body;
        logic [63:0]   mass_wide;
        logic [127:0]  inertia_wide;
        logic [63:0]   divisor;
        logic          clipped;
        if (vertices_in_polygon == 0) begin
            first_x = x;
            first_y = y;
        end else begin
            add_edge(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        if (vertices_in_polygon < MAX_VERTICES)
            vertices_in_polygon++;
        if (!last)
            return;

        body = '0;
        if (vertices_in_polygon == 1) begin
            body.mass   = {24'd0, body_density, 8'd0} * 5;
            body.status = STATUS_SINGLE;
        end else begin
            add_edge(x, y, first_x, first_y);
            if (area_sum == 0) begin
                body.status = STATUS_ZERO_AREA;
            end else begin
                clipped   = sums_saturated;
                mass_wide = ({24'd0, area_sum} * {48'd0, body_density}) >> 9;
                if (mass_wide > {16'd0, OUT_MAX}) begin
                    mass_wide = {16'd0, OUT_MAX};
                    clipped = 1'b1;
                end
                divisor      = {24'd0, area_sum} * 6;
                inertia_wide = {48'd0, moment_sum, 16'd0} / {64'd0, divisor};
                if (inertia_wide > {80'd0, OUT_MAX}) begin
                    inertia_wide = {80'd0, OUT_MAX};
                    clipped = 1'b1;
                end
                body.mass    = mass_wide[OUT_W-1:0];
                body.inertia = inertia_wide[OUT_W-1:0];
                body.status  = clipped ? STATUS_SATURATED : STATUS_OK;
            end
        end
        pending_bodies = {pending_bodies, body};
        vertices_in_polygon = 0;
        area_sum = '0;
        moment_sum = '0;
        sums_saturated = 1'b0;
        first_x = '0;
        first_y = '0;
        prev_x = '0;
        prev_y = '0;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {y, x};
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        accumulate_vertex(x, y, last);
        vertices_sent++;
        if (last)
            polygons_sent++;
        @(negedge aclk);
    endtask

    // Density is only written once the block has drained every polygon.
    task automatic set_density(input logic [DENS_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending_bodies.size() != 0) @(negedge aclk);
        repeat (IDLE_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        body_density = value;
        density_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 4))
            0: return 16'(int'($urandom_range(0, 1024)) - 512);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed_shapes();
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd256, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd256, 1'b1);
        // Two distinct points count their edge twice.
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
        send_vertex(16'sh8000, 16'sh8000, 1'b1);
        send_vertex(16'sd100, 16'sd100, 1'b0);
        send_vertex(16'sd100, 16'sd100, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b0);
        send_vertex(16'sd2, 16'sd2, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1);
        send_vertex(16'sh8000, 16'sh7FFF, 1'b1);
    endtask

    task automatic test_density_extremes();
        set_density(16'hFFFF);
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b0);
        send_vertex(16'sh0000, 16'sh7FFF, 1'b1);
        set_density(16'h0000);
        send_vertex(16'sd5, 16'sd5, 1'b1);
        send_vertex(-16'sd300, 16'sd40, 1'b0);
        send_vertex(16'sd700, -16'sd90, 1'b0);
        send_vertex(16'sd20, 16'sd999, 1'b1);
    endtask

    // More vertices than the counter counts up to (MAX_VERTICES) are still accumulated.
    task automatic test_vertex_count_limit();
        int k;
        set_density(16'd256);
        for (k = 0; k < MAX_VERTICES + 60; k++)
            send_vertex(random_coord(), random_coord(), k == MAX_VERTICES + 59);
    endtask

    // Edges between two far corners add about 2^31 each, enough to clip the
    // 40-bit area sum after some five hundred of them.
    task automatic test_area_saturation();
        int k;
        logic signed [COORD_W-1:0] x, y;
        set_density(16'h8001);
        for (k = 0; k < 650; k++) begin
            x = (k % 2 == 0) ? 16'($urandom_range(32000, 32767))
                             : 16'(-int'($urandom_range(32000, 32768)));
            y = 16'(-int'($urandom_range(32000, 32768)));
            send_vertex(x, y, k == 649);
        end
    endtask

    task automatic test_random_polygons(input int vertex_target);
        int phase, sent, count, k;
        logic collinear;
        logic signed [COORD_W-1:0] step_x, step_y;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_density(16'hFFFF);
                1: set_density(16'h0000);
                default: set_density(16'($urandom));
            endcase
            sent = 0;
            while (sent < vertex_target / 6) begin
                case ($urandom_range(0, 9))
                    0: count = 1;
                    1: count = 2;
                    2: count = $urandom_range(9, 40);
                    default: count = $urandom_range(3, 8);
                endcase
                collinear = ($urandom_range(0, 19) == 0);
                step_x = 16'(int'($urandom_range(0, 200)) - 100);
                step_y = 16'(int'($urandom_range(0, 200)) - 100);
                for (k = 0; k < count; k++) begin
                    if (collinear)
                        send_vertex(16'(k * step_x), 16'(k * step_y), k == count - 1);
                    else
                        send_vertex(random_coord(), random_coord(), k == count - 1);
                end
                sent += count;
            end
        end
    endtask

    // The result side stalls in stretches, each with its own ready rate.
    always @(negedge aclk) begin
        if (stretch_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 70;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
            stretch_left = $urandom_range(20, 300);
        end
        stretch_left--;
        m_tready = ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            status_seen[m_tuser]++;
            if (pending_bodies.size() == 0) begin
                report_mismatch($sformatf("unexpected result mass=%0h inertia=%0h status=%0d",
                                          m_tdata[47:0], m_tdata[95:48], m_tuser));
            end else begin
                oldest_body = pending_bodies.pop_front();
                if (m_tdata[47:0] !== oldest_body.mass)
                    report_mismatch($sformatf("mass got %0h want %0h",
                                              m_tdata[47:0], oldest_body.mass));
                if (m_tdata[95:48] !== oldest_body.inertia)
                    report_mismatch($sformatf("inertia got %0h want %0h",
                                              m_tdata[95:48], oldest_body.inertia));
                if (m_tuser !== oldest_body.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tuser, oldest_body.status));
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_shapes();
        test_density_extremes();
        test_vertex_count_limit();
        test_area_saturation();
        test_random_polygons(860);

        s_tvalid = 1'b0;
        while (pending_bodies.size() != 0) @(negedge aclk);
        repeat (IDLE_CYCLES) @(negedge aclk);
        if (pending_bodies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_bodies.size()));

        $display("Sent %0d polygons with %0d vertices under %0d density writes.",
                 polygons_sent, vertices_sent, density_writes);
        $display("Results seen: %0d ok, %0d single vertex, %0d zero area, %0d saturated.",
                 status_seen[STATUS_OK], status_seen[STATUS_SINGLE],
                 status_seen[STATUS_ZERO_AREA], status_seen[STATUS_SATURATED]);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* polygon_mass_and_inertia.f */
src/pmi_pkg.sv
src/pmi_mul.sv
src/pmi_div.sv
src/polygon_mass_and_inertia.sv
tb/tb_polygon_mass_and_inertia.sv
